>>> hdl/ptrlcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrlcd_pkg
// Shared types, constants and microcode program of the LCD row refresher.
// ----------------------------------------------------------------------------
package ptrlcd_pkg;

    localparam int FRAME_DEPTH = 1024;
    localparam int FRAME_AW    = 10;
    localparam int PC_W        = 4;

    // command codes of an input item
    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_REFRESH = 2'd1,
        CMD_INIT    = 2'd2
    } cmd_t;

    // result byte source
    typedef enum logic [1:0] {
        SRC_CONST = 2'd0,
        SRC_VADDR = 2'd1,
        SRC_HADDR = 2'd2,
        SRC_ACC   = 2'd3
    } src_t;

    // branch condition: taken goes to target, else to the next step
    typedef enum logic [2:0] {
        C_NEXT     = 3'd0,
        C_ALWAYS   = 3'd1,
        C_IDX_MORE = 3'd2,
        C_BIT_MORE = 3'd3,
        C_ROW_MORE = 3'd4
    } cond_t;

    typedef enum logic [1:0] {
        LAST_NO  = 2'd0,
        LAST_YES = 2'd1,
        LAST_ROW = 2'd2
    } last_t;

    typedef struct packed {
        logic            dispatch;
        logic            clr;
        logic            rd;
        logic            emit;
        logic            instr;
        src_t            src;
        last_t           last_sel;
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic [7:0]      cbyte;
    } ctl_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic       in_valid;
        logic [1:0] command;
        logic       out_free;
        logic       idx_end;
        logic       bit_end;
        logic       row_end;
    } stat_t;

    typedef struct packed {
        logic       instr;
        logic [7:0] lcd_byte;
        logic       last;
        logic       band_end;
    } res_t;

    // program entry points
    localparam logic [PC_W-1:0] PC_CLEAR    = 4'd0;
    localparam logic [PC_W-1:0] PC_DISPATCH = 4'd1;
    localparam logic [PC_W-1:0] PC_REFRESH  = 4'd2;
    localparam logic [PC_W-1:0] PC_GATHER   = 4'd4;
    localparam logic [PC_W-1:0] PC_INIT     = 4'd8;

    localparam logic [7:0] SET_ADDR = 8'h80;

    localparam logic [6:0] BAND_BOUND [6] = '{7'd0, 7'd13, 7'd26, 7'd39, 7'd52, 7'd64};

    function automatic logic ends_band(input logic [5:0] row);
        logic [6:0] nxt;
        logic       hit;
        nxt = {1'b0, row} + 7'd1;
        hit = 1'b0;
        for (int b = 1; b < 6; b++)
        begin
            if (nxt == BAND_BOUND[b])
                hit = 1'b1;
        end
        return hit;
    endfunction

    // microcode ROM
    function automatic ctl_t rom_word(input logic [PC_W-1:0] pc);
        ctl_t w;
        w          = '0;
        w.src      = SRC_CONST;
        w.last_sel = LAST_NO;
        w.cond     = C_NEXT;
        case (pc)
            4'd0:
            begin
                w.clr    = 1'b1;
                w.cond   = C_IDX_MORE;
                w.target = PC_CLEAR;
            end
            4'd1:  w.dispatch = 1'b1;
            4'd2:
            begin
                w.emit  = 1'b1;
                w.instr = 1'b1;
                w.src   = SRC_VADDR;
            end
            4'd3:
            begin
                w.emit  = 1'b1;
                w.instr = 1'b1;
                w.src   = SRC_HADDR;
            end
            4'd4:
            begin
                w.rd     = 1'b1;
                w.cond   = C_BIT_MORE;
                w.target = PC_GATHER;
            end
            4'd5:  w.cond = C_NEXT;        // last read data lands
            4'd6:
            begin
                w.emit     = 1'b1;
                w.src      = SRC_ACC;
                w.last_sel = LAST_ROW;
                w.cond     = C_ROW_MORE;
                w.target   = PC_GATHER;
            end
            4'd8, 4'd9, 4'd10, 4'd11, 4'd12:
            begin
                w.emit  = 1'b1;
                w.instr = 1'b1;
                case (pc)
                    4'd8:    w.cbyte = 8'h30;
                    4'd9:    w.cbyte = 8'h36;
                    4'd10:   w.cbyte = 8'h0C;
                    4'd11:   w.cbyte = 8'h01;
                    default: w.cbyte = 8'h06;
                endcase
                if (pc == 4'd12)
                begin
                    w.last_sel = LAST_YES;
                    w.cond     = C_ALWAYS;
                    w.target   = PC_DISPATCH;
                end
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = PC_DISPATCH;
            end
        endcase
        return w;
    endfunction

endpackage

>>> hdl/page_to_row_lcd_refresher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_to_row_lcd_refresher
// 128x64 page-layout frame store feeding row-ordered LCD refresh bytes.
// ----------------------------------------------------------------------------
//  channel | signals                                  | role
//  --------+------------------------------------------+---------------------
//  in      | in_valid, in_stall, command/address/data | items to the block
//  out     | out_valid, out_stall, is_instruction,    | LCD bus bytes out
//          | lcd_byte, last, band_end                 |
//
//  After reset the frame store is zeroed, one byte per cycle, with
//  in_stall high. A write item is stored on its dispatch step. An init
//  item is dispatched and then sends five instruction bytes. A refresh
//  item sends 2 address instructions, then per data byte 8 reads
//  through the single frame store read port, a step in which the last
//  read data lands and the step that sends the byte. Output stalls hold
//  the sequencer on its emit step; a new item is taken only on the
//  dispatch step, with the last result possibly still waiting in the output register.
// ----------------------------------------------------------------------------
module page_to_row_lcd_refresher
    import ptrlcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] command,
    input  logic [9:0] address,
    input  logic [7:0] data,

    output logic       out_valid,
    input  logic       out_stall,
    output logic       is_instruction,
    output logic [7:0] lcd_byte,
    output logic       last,
    output logic       band_end
);

    ctl_t  ctl;
    stat_t stat;
    res_t  res;
    logic  fire;
    logic  idx_end;
    logic  bit_end;
    logic  row_end;
    logic  out_free;
    logic  load;

    logic  out_valid_reg;
    logic  out_valid_next;
    res_t  out_res_reg;

    // output register is free when empty or draining this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !ctl.dispatch;

    always_comb
    begin
        stat.in_valid = in_valid;
        stat.command  = command;
        stat.out_free = out_free;
        stat.idx_end  = idx_end;
        stat.bit_end  = bit_end;
        stat.row_end  = row_end;
    end

    ptrlcd_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl),
        .fire  (fire)
    );

    ptrlcd_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .fire    (fire),
        .command (command),
        .address (address),
        .data    (data),
        .idx_end (idx_end),
        .bit_end (bit_end),
        .row_end (row_end),
        .res     (res)
    );

    assign load = fire && ctl.emit;

    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_res_reg <= res;
    end

    assign out_valid      = out_valid_reg;
    assign is_instruction = out_res_reg.instr;
    assign lcd_byte       = out_res_reg.lcd_byte;
    assign last           = out_res_reg.last;
    assign band_end       = out_res_reg.band_end;

endmodule

>>> hdl/ptrlcd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrlcd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ptrlcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/ptrlcd_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrlcd_seq
// Step counter and microcode ROM with conditional jumps.
// ----------------------------------------------------------------------------
module ptrlcd_seq
    import ptrlcd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctl_t  ctl,
    output logic  fire
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic [PC_W-1:0] pc_inc;
    logic            taken;

    assign ctl    = rom_word(pc_reg);
    assign pc_inc = pc_reg + 1'b1;

    // a step executes unless it waits on a handshake
    always_comb
    begin
        if (ctl.emit)
            fire = stat.out_free;
        else if (ctl.dispatch)
            fire = stat.in_valid;
        else
            fire = 1'b1;
    end

    always_comb
    begin
        unique case (ctl.cond)
            C_NEXT:     taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_IDX_MORE: taken = !stat.idx_end;
            C_BIT_MORE: taken = !stat.bit_end;
            C_ROW_MORE: taken = !stat.row_end;
            default:    taken = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (fire)
        begin
            if (ctl.dispatch)
            begin
                unique case (stat.command)
                    CMD_REFRESH: pc_next = PC_REFRESH;
                    CMD_INIT:    pc_next = PC_INIT;
                    default:     pc_next = PC_DISPATCH;
                endcase
            end
            else if (taken)
                pc_next = ctl.target;
            else
                pc_next = pc_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= PC_CLEAR;
        else
            pc_reg <= pc_next;
    end

endmodule

>>> hdl/ptrlcd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrlcd_dp
// Frame store, byte index, row counter and bit gather register.
// ----------------------------------------------------------------------------
module ptrlcd_dp
    import ptrlcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctl_t       ctl,
    input  logic       fire,
    input  logic [1:0] command,
    input  logic [9:0] address,
    input  logic [7:0] data,
    output logic       idx_end,
    output logic       bit_end,
    output logic       row_end,
    output res_t       res
);

    logic [FRAME_AW-1:0] idx_reg;
    logic [FRAME_AW-1:0] idx_next;
    logic [5:0]          row_reg;
    logic [5:0]          row_next;
    logic [7:0]          acc_reg;
    logic [7:0]          acc_next;
    logic                rd_vld_reg;

    logic                we;
    logic [FRAME_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic [FRAME_AW-1:0] raddr;
    logic [7:0]          rdata;
    logic                adv_row;

    assign idx_end = (idx_reg == {FRAME_AW{1'b1}});
    assign bit_end = (idx_reg[2:0] == 3'd7);
    assign row_end = (idx_reg[6:0] == 7'd0);

    assign we    = ctl.clr || (ctl.dispatch && fire && (command == CMD_WRITE));
    assign waddr = ctl.clr ? idx_reg : address;
    assign wdata = ctl.clr ? 8'h00 : data;
    // page of the row, then column x*8+b
    assign raddr = {row_reg[5:3], idx_reg[6:0]};

    ptrlcd_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign adv_row = fire && ctl.emit && (ctl.src == SRC_ACC) && row_end;

    always_comb
    begin
        idx_next = idx_reg;
        if (fire && (ctl.clr || ctl.rd))
            idx_next = idx_reg + 1'b1;
        row_next = adv_row ? row_reg + 1'b1 : row_reg;
        // MSB first: first page byte ends up in bit 7
        acc_next = rd_vld_reg ? {acc_reg[6:0], rdata[row_reg[2:0]]} : acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            row_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            idx_reg    <= idx_next;
            row_reg    <= row_next;
            rd_vld_reg <= ctl.rd && fire;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    always_comb
    begin
        res.instr = ctl.instr;
        case (ctl.src)
            SRC_VADDR: res.lcd_byte = SET_ADDR | {3'b000, row_reg[4:0]};
            SRC_HADDR: res.lcd_byte = SET_ADDR | {4'b0000, row_reg[5], 3'b000};
            SRC_ACC:   res.lcd_byte = acc_reg;
            default:   res.lcd_byte = ctl.cbyte;
        endcase
        case (ctl.last_sel)
            LAST_YES: res.last = 1'b1;
            LAST_ROW: res.last = row_end;
            default:  res.last = 1'b0;
        endcase
        res.band_end = (ctl.src == SRC_ACC) && row_end && ends_band(row_reg);
    end

`ifndef SYNTH
    a_row_moves_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(row_reg) |-> $past(adv_row))
        else $error("row counter moved outside the last data byte");

    a_byte_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && ctl.emit && (ctl.src == SRC_ACC)) |-> (idx_reg[2:0] == 3'd0))
        else $error("data byte emitted before 8 bits were gathered");

    a_gather_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> $past(ctl.rd && fire))
        else $error("gather without a read the cycle before");
`endif

endmodule
